// ----- src/abbt_pkg.sv -----
// ----------------------------------------------------------------------------
// abbt_pkg
// Types and codes shared by the bounding box tracker: beat payloads,
// configuration set, action and register codes, queue sizing.
// ----------------------------------------------------------------------------
package abbt_pkg;

	// action codes of an input beat
	localparam logic [1:0] ACT_POINT    = 2'd0;
	localparam logic [1:0] ACT_END_PAGE = 2'd1;
	localparam logic [1:0] ACT_END_DOC  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN   = 3'd6;

	// box kind codes
	localparam logic KIND_PAGE = 1'b0;
	localparam logic KIND_DOC  = 1'b1;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic               page_printed;
	} item_t;

	typedef struct packed {
		logic               box_kind;
		logic signed [15:0] left;
		logic signed [15:0] bottom;
		logic signed [15:0] right;
		logic signed [15:0] top;
	} box_t;

	typedef struct packed {
		logic signed [31:0] matrix_a;
		logic signed [31:0] matrix_b;
		logic signed [31:0] matrix_c;
		logic signed [31:0] matrix_d;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic signed [7:0]  margin;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ----- src/abbt_queue.sv -----
// ----------------------------------------------------------------------------
// abbt_queue
// Short job queue between the front and the back of the tracker.
// ----------------------------------------------------------------------------
module abbt_queue #(
	parameter int WIDTH = 129
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [WIDTH-1:0]   wdata,
	input  logic               pop,
	output logic [WIDTH-1:0]   rdata,
	output abbt_pkg::queue_stat_t stat
);
	import abbt_pkg::*;

	logic [WIDTH-1:0]       mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	// status and head entry
	assign stat.full  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/abbt_front.sv -----
// ----------------------------------------------------------------------------
// abbt_front
// Takes input beats, grows the page box, keeps the document box and hands
// each box to be emitted to the job queue.
// ----------------------------------------------------------------------------
module abbt_front #(
	parameter int PW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  abbt_pkg::item_t       item,
	input  abbt_pkg::queue_stat_t stat,
	output logic                  push,
	output logic [4*PW:0]         job
);
	import abbt_pkg::*;

	localparam logic signed [31:0] PT_MAX = 32'((64'sd1 <<< (PW - 1)) - 64'sd1);
	localparam logic signed [31:0] PT_MIN = ~PT_MAX;

	logic                 page_valid_q, page_valid_n;
	logic signed [PW-1:0] page_q [4];
	logic signed [PW-1:0] page_n [4];
	logic                 doc_valid_q, doc_valid_n;
	logic signed [PW-1:0] doc_q [4];
	logic signed [PW-1:0] doc_n [4];

	logic                 accept;
	logic                 sel_valid;
	logic signed [PW-1:0] sel [4];
	logic signed [PW-1:0] merged [4];
	logic signed [PW-1:0] pt_x, pt_y;
	logic                 kind;

	function automatic logic signed [PW-1:0] sat_pt(input logic signed [31:0] v);
		logic signed [31:0] r;
		r = v;
		if (v > PT_MAX) begin
			r = PT_MAX;
		end else if (v < PT_MIN) begin
			r = PT_MIN;
		end
		return r[PW-1:0];
	endfunction

	assign item_ready = !stat.full;
	assign accept     = item_valid && item_ready;
	assign pt_x       = sat_pt(item.point_x);
	assign pt_y       = sat_pt(item.point_y);
	assign kind       = (item.action == ACT_END_DOC) ? KIND_DOC : KIND_PAGE;
	assign job        = {kind, sel[3], sel[2], sel[1], sel[0]};

	// selected box and its merge with the document box
	always_comb begin
		sel_valid = (item.action == ACT_END_DOC) ? doc_valid_q : page_valid_q;
		for (int i = 0; i < 4; i++) begin
			sel[i] = (item.action == ACT_END_DOC) ? doc_q[i] : page_q[i];
		end
		for (int i = 0; i < 4; i++) begin
			merged[i] = sel[i];
		end
		if (doc_valid_q) begin
			if (!sel_valid) begin
				for (int i = 0; i < 4; i++) begin
					merged[i] = doc_q[i];
				end
			end else begin
				merged[0] = (doc_q[0] < sel[0]) ? doc_q[0] : sel[0];
				merged[1] = (doc_q[1] < sel[1]) ? doc_q[1] : sel[1];
				merged[2] = (doc_q[2] > sel[2]) ? doc_q[2] : sel[2];
				merged[3] = (doc_q[3] > sel[3]) ? doc_q[3] : sel[3];
			end
		end
	end

	// next state per accepted beat
	always_comb begin
		page_valid_n = page_valid_q;
		doc_valid_n  = doc_valid_q;
		for (int i = 0; i < 4; i++) begin
			page_n[i] = page_q[i];
			doc_n[i]  = doc_q[i];
		end
		push = 1'b0;
		if (accept) begin
			case (item.action)
				ACT_POINT: begin
					page_valid_n = 1'b1;
					if (!page_valid_q) begin
						page_n[0] = pt_x;
						page_n[1] = pt_y;
						page_n[2] = pt_x;
						page_n[3] = pt_y;
					end else begin
						if (pt_x < page_q[0]) page_n[0] = pt_x;
						if (pt_y < page_q[1]) page_n[1] = pt_y;
						if (pt_x > page_q[2]) page_n[2] = pt_x;
						if (pt_y > page_q[3]) page_n[3] = pt_y;
					end
				end
				ACT_END_PAGE, ACT_END_DOC: begin
					push         = sel_valid;
					page_valid_n = 1'b0;
					if (item.page_printed) begin
						doc_valid_n = sel_valid || doc_valid_q;
						for (int i = 0; i < 4; i++) begin
							doc_n[i] = merged[i];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// box corners
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			page_q[i] <= page_n[i];
			doc_q[i]  <= doc_n[i];
		end
	end

	// box valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_valid_q <= 1'b0;
			doc_valid_q  <= 1'b0;
		end else begin
			page_valid_q <= page_valid_n;
			doc_valid_q  <= doc_valid_n;
		end
	end

endmodule

// ----- src/abbt_back.sv -----
// ----------------------------------------------------------------------------
// abbt_back
// Maps a box through the affine matrix, bounds the corners, applies the
// margin and converts each side to saturated whole units.
// ----------------------------------------------------------------------------
module abbt_back #(
	parameter int PW        = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  abbt_pkg::cfg_t        cfg,
	input  abbt_pkg::queue_stat_t stat,
	input  logic [4*PW:0]         job,
	output logic                  pop,
	output logic                  box_valid,
	input  logic                  box_ready,
	output abbt_pkg::box_t        box
);
	import abbt_pkg::*;

	localparam int PROD_W = 32 + PW;
	localparam int SUM_W  = PROD_W + 1;
	localparam int XW     = SUM_W + 1;
	localparam int VW     = XW + 1;
	localparam logic signed [VW-1:0] SAT_HI = VW'(32767);
	localparam logic signed [VW-1:0] SAT_LO = -VW'(32768);
	localparam logic signed [VW-1:0] BIAS   = (VW'(1) <<< FRAC_BITS) - VW'(1);

	logic adv;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic                 kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;
	logic signed [PW-1:0] x0_s1, y0_s1, x1_s1, y1_s1;

	logic signed [PROD_W-1:0] ax0_s2, ax1_s2, cy0_s2, cy1_s2;
	logic signed [PROD_W-1:0] bx0_s2, bx1_s2, dy0_s2, dy1_s2;

	logic signed [XW-1:0] px_s3 [4];
	logic signed [XW-1:0] py_s3 [4];
	logic signed [XW-1:0] px_c [4];
	logic signed [XW-1:0] py_c [4];

	logic signed [XW-1:0] minx_s4, miny_s4, maxx_s4, maxy_s4;
	logic signed [XW-1:0] minx_c, miny_c, maxx_c, maxy_c;

	logic signed [VW-1:0] adj;
	logic signed [VW-1:0] l_s5, b_s5, r_s5, t_s5;

	box_t box_s6;

	// floor((p + q) / 2^frac) + offset
	function automatic logic signed [XW-1:0] map_coord(
		input logic signed [PROD_W-1:0] p,
		input logic signed [PROD_W-1:0] q,
		input logic signed [31:0]       off
	);
		logic signed [SUM_W-1:0] s;
		s = SUM_W'(p) + SUM_W'(q);
		return XW'(s >>> FRAC_BITS) + XW'(off);
	endfunction

	// truncate toward zero to whole units, then saturate
	function automatic logic signed [15:0] to_unit(input logic signed [VW-1:0] v);
		logic signed [VW-1:0] t;
		t = (v + (v[VW-1] ? BIAS : VW'(0))) >>> FRAC_BITS;
		if (t > SAT_HI) begin
			t = SAT_HI;
		end else if (t < SAT_LO) begin
			t = SAT_LO;
		end
		return t[15:0];
	endfunction

	// whole pipeline moves when the output slot frees
	assign adv       = !v_s6 || box_ready;
	assign pop       = adv && !stat.empty;
	assign box_valid = v_s6;
	assign box       = box_s6;

	// corner combinations: (x0,y0) (x0,y1) (x1,y1) (x1,y0)
	always_comb begin
		px_c[0] = map_coord(ax0_s2, cy0_s2, cfg.offset_x);
		px_c[1] = map_coord(ax0_s2, cy1_s2, cfg.offset_x);
		px_c[2] = map_coord(ax1_s2, cy1_s2, cfg.offset_x);
		px_c[3] = map_coord(ax1_s2, cy0_s2, cfg.offset_x);
		py_c[0] = map_coord(bx0_s2, dy0_s2, cfg.offset_y);
		py_c[1] = map_coord(bx0_s2, dy1_s2, cfg.offset_y);
		py_c[2] = map_coord(bx1_s2, dy1_s2, cfg.offset_y);
		py_c[3] = map_coord(bx1_s2, dy0_s2, cfg.offset_y);
	end

	// bounds of the mapped corners
	always_comb begin
		minx_c = px_s3[0];
		maxx_c = px_s3[0];
		miny_c = py_s3[0];
		maxy_c = py_s3[0];
		for (int i = 1; i < 4; i++) begin
			if (px_s3[i] < minx_c) minx_c = px_s3[i];
			if (px_s3[i] > maxx_c) maxx_c = px_s3[i];
			if (py_s3[i] < miny_c) miny_c = py_s3[i];
			if (py_s3[i] > maxy_c) maxy_c = py_s3[i];
		end
	end

	// margin plus one half, in fraction units
	assign adj = (VW'(cfg.margin) <<< FRAC_BITS) + (VW'(1) <<< (FRAC_BITS - 1));

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= job[4*PW];
			x0_s1   <= job[PW-1:0];
			y0_s1   <= job[2*PW-1:PW];
			x1_s1   <= job[3*PW-1:2*PW];
			y1_s1   <= job[4*PW-1:3*PW];

			kind_s2 <= kind_s1;
			ax0_s2  <= cfg.matrix_a * x0_s1;
			ax1_s2  <= cfg.matrix_a * x1_s1;
			cy0_s2  <= cfg.matrix_c * y0_s1;
			cy1_s2  <= cfg.matrix_c * y1_s1;
			bx0_s2  <= cfg.matrix_b * x0_s1;
			bx1_s2  <= cfg.matrix_b * x1_s1;
			dy0_s2  <= cfg.matrix_d * y0_s1;
			dy1_s2  <= cfg.matrix_d * y1_s1;

			kind_s3 <= kind_s2;
			for (int i = 0; i < 4; i++) begin
				px_s3[i] <= px_c[i];
				py_s3[i] <= py_c[i];
			end

			kind_s4 <= kind_s3;
			minx_s4 <= minx_c;
			miny_s4 <= miny_c;
			maxx_s4 <= maxx_c;
			maxy_s4 <= maxy_c;

			kind_s5 <= kind_s4;
			l_s5    <= VW'(minx_s4) - adj;
			b_s5    <= VW'(miny_s4) - adj;
			r_s5    <= VW'(maxx_s4) + adj;
			t_s5    <= VW'(maxy_s4) + adj;

			box_s6.box_kind <= kind_s5;
			box_s6.left     <= to_unit(l_s5);
			box_s6.bottom   <= to_unit(b_s5);
			box_s6.right    <= to_unit(r_s5);
			box_s6.top      <= to_unit(t_s5);
		end
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !stat.empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

endmodule

// ----- src/affine_bounding_box_tracker_core.sv -----
// ----------------------------------------------------------------------------
// affine_bounding_box_tracker_core
// Tracks page and document boxes of Q16.16 points and emits each box mapped
// through an affine matrix, widened by a margin, in saturated whole units.
//
//   channel  signals                              direction
//   item     item_valid item_ready item           beats in
//   box      box_valid box_ready box              beats out
//   cfg      cfg_valid cfg_ready cfg_index cfg_data  register writes in
//
// One input beat is taken per cycle while the queue is not full; points
// update the page box at once. An end beat with a valid box reaches the box
// port through a four-entry job queue feeding a six-stage mapping pipeline.
// A stall on box_ready holds the pipeline; item_ready drops only when the
// queue is full. Reset is immediate, no clearing pass; cfg_ready is always high.
// ----------------------------------------------------------------------------
module affine_bounding_box_tracker_core #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  abbt_pkg::item_t                  item,
	output logic                             box_valid,
	input  logic                             box_ready,
	output abbt_pkg::box_t                   box,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [abbt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                      cfg_data
);
	import abbt_pkg::*;

	localparam int PW    = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int JOB_W = 4 * PW + 1;

	cfg_t              cfg_q;
	queue_stat_t       stat;
	logic              push;
	logic              pop;
	logic [JOB_W-1:0]  job_in;
	logic [JOB_W-1:0]  job_out;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.matrix_a <= 32'(64'sd1 <<< FRAC_BITS);
			cfg_q.matrix_b <= '0;
			cfg_q.matrix_c <= '0;
			cfg_q.matrix_d <= 32'(64'sd1 <<< FRAC_BITS);
			cfg_q.offset_x <= '0;
			cfg_q.offset_y <= '0;
			cfg_q.margin   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MATRIX_A: cfg_q.matrix_a <= cfg_data;
				REG_MATRIX_B: cfg_q.matrix_b <= cfg_data;
				REG_MATRIX_C: cfg_q.matrix_c <= cfg_data;
				REG_MATRIX_D: cfg_q.matrix_d <= cfg_data;
				REG_OFFSET_X: cfg_q.offset_x <= cfg_data;
				REG_OFFSET_Y: cfg_q.offset_y <= cfg_data;
				REG_MARGIN:   cfg_q.margin   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// point tracking and box selection
	abbt_front #(
		.PW(PW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.stat       (stat),
		.push       (push),
		.job        (job_in)
	);

	// job queue
	abbt_queue #(
		.WIDTH(JOB_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.pop    (pop),
		.rdata  (job_out),
		.stat   (stat)
	);

	// transform and output conversion
	abbt_back #(
		.PW        (PW),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.stat      (stat),
		.job       (job_out),
		.pop       (pop),
		.box_valid (box_valid),
		.box_ready (box_ready),
		.box       (box)
	);

endmodule
